// ----- rtl/teq_pkg.sv -----
// Shared types, codes and helpers for the timed event queue.
package teq_pkg;

  localparam int unsigned DueW = 48;
  localparam int unsigned PerW = 40;
  localparam int unsigned IdW  = 31;
  localparam int unsigned CfgW = 20;

  localparam logic [IdW-1:0]  ID_RESET     = 31'd32768;
  localparam logic [CfgW-1:0] WINDOW_RESET = 20'd10000;
  localparam logic [CfgW-1:0] MIN_IV_RESET = 20'd100;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_ALARM  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    RES_ADDED    = 3'd0,
    RES_REMOVED  = 3'd1,
    RES_NOTFOUND = 3'd2,
    RES_FULL     = 3'd3,
    RES_FIRED    = 3'd4,
    RES_DONE     = 3'd5
  } res_e;

  typedef enum logic {
    CFG_WINDOW = 1'b0,
    CFG_MIN_IV = 1'b1
  } cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_OUT,
    ST_INS_SCAN,
    ST_INS_CMP,
    ST_INS_SHIFT,
    ST_INS_MOV,
    ST_INS_WR,
    ST_REM_SCAN,
    ST_REM_CMP,
    ST_DEL_SHIFT,
    ST_DEL_MOV,
    ST_DEL_DONE,
    ST_REM_HEAD,
    ST_AL_HEAD,
    ST_AL_CHK,
    ST_AL_PER,
    ST_AL_CU,
    ST_AL_DIV,
    ST_AL_ADD,
    ST_AL_DONE,
    ST_AL_DLAST
  } state_e;

  typedef struct packed {
    logic [DueW-1:0] due;
    logic [PerW-1:0] per;
    logic [IdW-1:0]  ident;
  } entry_t;

  // max(due - now clipped at zero, min interval)
  function automatic logic [DueW-1:0] head_ivl(logic [DueW-1:0] due,
                                               logic [DueW-1:0] now,
                                               logic [CfgW-1:0] min_iv);
    logic [DueW-1:0] d;
    d = (due > now) ? (due - now) : '0;
    return (d < {28'd0, min_iv}) ? {28'd0, min_iv} : d;
  endfunction

endpackage

// ----- rtl/teq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module teq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/teq_rem.sv -----
// Bit-serial remainder unit: dividend mod divisor, one bit per cycle.
module teq_rem
  import teq_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DueW-1:0] dividend_i,
  input  logic [PerW-1:0] divisor_i,
  output logic            done_o,
  output logic [PerW-1:0] rem_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [DueW-1:0] dvd_q, dvd_d;
  logic [PerW-1:0] rem_q, rem_d;
  logic [PerW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[DueW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'(DueW - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        trial = trial - {1'b0, divisor_i};
      end
      rem_d = trial[PerW-1:0];
      dvd_d = {dvd_q[DueW-2:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/timed_event_queue.sv -----
// Timed event queue: top level with sequencer, slot RAM and remainder unit.
//
// Keeps up to QUEUE_DEPTH events sorted by due time in a single-port-read
// RAM, equal due times in arrival order. One request is handled at a time;
// s_axis_tready is high only while idle. An add walks the sorted slots and
// shifts the tail up by one; a remove walks and shifts down the same way.
// An alarm repeats, per fired event, a head check, a delete of the head,
// and for periodic events a reinsert; when a periodic event is more than
// two periods late, a bit-serial remainder unit computes the catch-up. An
// alarm fires at most MAX_FIRES events.
// Results leave through an output register, so the sequencer stalls only
// when a previous result has not been taken yet. Configuration: byte
// address 0 fire window, 4 minimum timer interval, both 20 bits.
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MAX_FIRES   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: now_us[47:0], start_offset_us[87:48], period_us[127:88],
  //        target_id[158:128], zero fill
  input  logic [159:0] s_axis_tdata,
  // tuser: req_type
  input  logic [1:0]   s_axis_tuser,
  // stream out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: event_id[30:0], timer_arm[31], timer_interval_us[79:32],
  //        queue_empty[80], zero fill
  output logic [87:0]  m_axis_tdata,
  // tuser: result_kind
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  // config
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NW = $clog2(MAX_FIRES + 1);
  localparam int unsigned EW = $bits(entry_t);

  // ---------------- configuration registers
  logic [CfgW-1:0] win_q, miv_q;

  assign pready = 1'b1;
  assign prdata = (cfg_e'(paddr[2]) == CFG_MIN_IV) ? {12'd0, miv_q} : {12'd0, win_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WINDOW_RESET;
      miv_q <= MIN_IV_RESET;
    end else if (psel && penable && pwrite) begin
      if (cfg_e'(paddr[2]) == CFG_MIN_IV) begin
        miv_q <= pwdata[CfgW-1:0];
      end else begin
        win_q <= pwdata[CfgW-1:0];
      end
    end
  end

  // ---------------- state
  state_e          state_q, state_d, after_q, after_d;
  req_e            op_q, op_d;
  logic [CW-1:0]   cnt_q, cnt_d, idx_q, idx_d, pos_q, pos_d, j_q, j_d;
  logic [NW-1:0]   nf_q, nf_d;
  logic [IdW-1:0]  idc_q, idc_d, id_q, id_d, tid_q, tid_d;
  logic [DueW-1:0] now_q, now_d, due_q, due_d, gap_q, gap_d;
  logic [PerW-1:0] per_q, per_d;
  logic [DueW:0]   dd_q, dd_d, kp_q, kp_d;
  // staged result and output register
  res_e            kind_q, kind_d, okind_q, okind_d;
  logic [IdW-1:0]  eid_q, eid_d, oeid_q, oeid_d;
  logic            arm_q, arm_d, oarm_q, oarm_d, last_q, last_d, olast_q, olast_d;
  logic [DueW-1:0] ivl_q, ivl_d, oivl_q, oivl_d;
  logic            oemp_q, oemp_d, ovld_q, ovld_d;

  // ---------------- RAM and remainder unit
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, rd;
  logic          rem_start, rem_done;
  logic [PerW-1:0] rem_val;

  teq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  // dividend is taken in the same cycle the gap is formed
  teq_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (gap_d),
    .divisor_i  (per_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // ---------------- shared conditions
  logic            s_fire, out_free, full, rd_late, behind, del_end, id_hit;
  logic [DueW:0]   add_sum;
  logic [DueW-1:0] rd_dist;
  logic [DueW+1:0] cu_sum, fin_sum;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovld_q || m_axis_tready;
  assign full     = (cnt_q == CW'(QUEUE_DEPTH));
  assign add_sum  = {1'b0, s_axis_tdata[47:0]} + {9'd0, s_axis_tdata[87:48]};
  assign rd_dist  = (rd.due > now_q) ? (rd.due - now_q) : '0;
  assign rd_late  = (rd_dist > {28'd0, win_q});
  assign cu_sum   = {1'b0, dd_q} + {10'd0, per_q};
  assign behind   = (cu_sum < {2'd0, now_q});
  assign fin_sum  = {1'b0, dd_q} + {1'b0, kp_q};
  assign del_end  = ({1'b0, j_q} + 1'b1) >= {1'b0, cnt_q};
  assign id_hit   = (rd.ident == tid_q);

  // ---------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          case (req_e'(s_axis_tuser))
            REQ_ADD:    state_d = full ? ST_OUT : ST_INS_SCAN;
            REQ_REMOVE: state_d = ST_REM_SCAN;
            REQ_ALARM:  state_d = ST_AL_HEAD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_OUT:       if (out_free) state_d = after_q;
      ST_INS_SCAN:  state_d = (idx_q == cnt_q) ? ST_INS_SHIFT : ST_INS_CMP;
      ST_INS_CMP:   state_d = (rd.due <= due_q) ? ST_INS_SCAN : ST_INS_SHIFT;
      ST_INS_SHIFT: state_d = (j_q == pos_q) ? ST_INS_WR : ST_INS_MOV;
      ST_INS_MOV:   state_d = ST_INS_SHIFT;
      ST_INS_WR:    state_d = ST_OUT;
      ST_REM_SCAN:  state_d = (idx_q == cnt_q) ? ST_OUT : ST_REM_CMP;
      ST_REM_CMP:   state_d = id_hit ? ST_DEL_SHIFT : ST_REM_SCAN;
      ST_DEL_SHIFT: state_d = del_end ? ST_DEL_DONE : ST_DEL_MOV;
      ST_DEL_MOV:   state_d = ST_DEL_SHIFT;
      ST_DEL_DONE: begin
        if (op_q == REQ_REMOVE) begin
          state_d = (pos_q == '0 && cnt_q != '0) ? ST_REM_HEAD : ST_OUT;
        end else begin
          state_d = ST_AL_PER;
        end
      end
      ST_REM_HEAD:  state_d = ST_OUT;
      ST_AL_HEAD: begin
        state_d = (cnt_q == '0 || nf_q == NW'(MAX_FIRES)) ? ST_AL_DONE : ST_AL_CHK;
      end
      ST_AL_CHK:    state_d = rd_late ? ST_AL_DONE : ST_DEL_SHIFT;
      ST_AL_PER:    state_d = (per_q == '0) ? ST_OUT : ST_AL_CU;
      ST_AL_CU:     state_d = behind ? ST_AL_DIV : ST_INS_SCAN;
      ST_AL_DIV:    if (rem_done) state_d = ST_AL_ADD;
      ST_AL_ADD:    state_d = ST_INS_SCAN;
      ST_AL_DONE:   state_d = (cnt_q != '0) ? ST_AL_DLAST : ST_OUT;
      ST_AL_DLAST:  state_d = ST_OUT;
      default:      state_d = ST_IDLE;
    endcase
  end

  // ---------------- datapath and outputs
  always_comb begin
    after_d = after_q;  op_d  = op_q;   cnt_d = cnt_q;  idx_d = idx_q;
    pos_d   = pos_q;    j_d   = j_q;    nf_d  = nf_q;   idc_d = idc_q;
    id_d    = id_q;     tid_d = tid_q;  now_d = now_q;  due_d = due_q;
    gap_d   = gap_q;    per_d = per_q;  dd_d  = dd_q;   kp_d  = kp_q;
    kind_d  = kind_q;   eid_d = eid_q;  arm_d = arm_q;  last_d = last_q;
    ivl_d   = ivl_q;
    okind_d = okind_q;  oeid_d = oeid_q; oarm_d = oarm_q; olast_d = olast_q;
    oivl_d  = oivl_q;   oemp_d = oemp_q;
    ovld_d  = ovld_q && !m_axis_tready;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '{due: due_q, per: per_q, ident: id_q};
    ram_raddr = '0;
    rem_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          op_d  = req_e'(s_axis_tuser);
          now_d = s_axis_tdata[47:0];
          per_d = s_axis_tdata[127:88];
          tid_d = s_axis_tdata[158:128];
          idx_d = '0;
          nf_d  = '0;
          // add into a full table: nothing changes, no id taken
          kind_d = RES_FULL; eid_d = '0; arm_d = 1'b0; ivl_d = '0; last_d = 1'b1;
          after_d = ST_IDLE;
          if (req_e'(s_axis_tuser) == REQ_ADD && !full) begin
            idc_d = idc_q + 1'b1;
            id_d  = idc_q + 1'b1;
            due_d = add_sum[DueW] ? '1 : add_sum[DueW-1:0];
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ovld_d = 1'b1;  okind_d = kind_q; oeid_d = eid_q; oarm_d = arm_q;
          oivl_d = ivl_q; olast_d = last_q; oemp_d = (cnt_q == '0);
        end
      end
      // sorted insert: find first slot with later due, shift tail up
      ST_INS_SCAN: begin
        ram_raddr = idx_q[AW-1:0];
        if (idx_q == cnt_q) begin
          pos_d = idx_q;
          j_d   = cnt_q;
        end
      end
      ST_INS_CMP: begin
        if (rd.due <= due_q) begin
          idx_d = idx_q + 1'b1;
        end else begin
          pos_d = idx_q;
          j_d   = cnt_q;
        end
      end
      ST_INS_SHIFT: ram_raddr = AW'(j_q - 1'b1);
      ST_INS_MOV: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[AW-1:0];
        ram_wdata = rd;
        j_d       = j_q - 1'b1;
      end
      ST_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        cnt_d     = cnt_q + 1'b1;
        eid_d     = id_q;
        ivl_d     = '0;
        arm_d     = 1'b0;
        if (op_q == REQ_ADD) begin
          kind_d  = RES_ADDED;
          last_d  = 1'b1;
          after_d = ST_IDLE;
          if (pos_q == '0) begin
            arm_d = 1'b1;
            ivl_d = head_ivl(due_q, now_q, miv_q);
          end
        end else begin
          kind_d  = RES_FIRED;
          last_d  = 1'b0;
          after_d = ST_AL_HEAD;
          nf_d    = nf_q + 1'b1;
        end
      end
      // remove by id: first match in sorted order
      ST_REM_SCAN: begin
        ram_raddr = idx_q[AW-1:0];
        kind_d = RES_NOTFOUND; eid_d = tid_q; arm_d = 1'b0; ivl_d = '0;
        last_d = 1'b1; after_d = ST_IDLE;
      end
      ST_REM_CMP: begin
        if (id_hit) begin
          pos_d = idx_q;
          j_d   = idx_q;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DEL_SHIFT: begin
        ram_raddr = AW'(j_q + 1'b1);
        if (del_end) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DEL_MOV: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[AW-1:0];
        ram_wdata = rd;
        j_d       = j_q + 1'b1;
      end
      ST_DEL_DONE: begin
        ram_raddr = '0;
        kind_d = RES_REMOVED; eid_d = tid_q; arm_d = 1'b0; ivl_d = '0;
        last_d = 1'b1; after_d = ST_IDLE;
        if (op_q == REQ_ALARM) begin
          // one-shot fired event; periodic ones go on to catch-up
          kind_d  = RES_FIRED; eid_d = id_q; last_d = 1'b0;
          after_d = ST_AL_HEAD;
          if (per_q == '0) begin
            nf_d = nf_q + 1'b1;
          end
        end
      end
      ST_REM_HEAD: begin
        arm_d = 1'b1;
        ivl_d = head_ivl(rd.due, now_q, miv_q);
      end
      // alarm: look at head
      ST_AL_HEAD: ram_raddr = '0;
      ST_AL_CHK: begin
        if (!rd_late) begin
          due_d = rd.due;
          per_d = rd.per;
          id_d  = rd.ident;
          pos_d = '0;
          j_d   = '0;
        end
      end
      ST_AL_PER: dd_d = {1'b0, due_q} + {9'd0, per_q};
      ST_AL_CU: begin
        idx_d = '0;
        if (behind) begin
          gap_d     = DueW'({2'd0, now_q} - {10'd0, per_q} - {1'b0, dd_q});
          rem_start = 1'b1;
        end else begin
          due_d = dd_q[DueW] ? '1 : dd_q[DueW-1:0];
        end
      end
      ST_AL_DIV: begin
        // k*p = gap rounded up to a multiple of the period
        if (rem_done) begin
          kp_d = (rem_val == '0) ? {1'b0, gap_q}
                                 : {1'b0, gap_q} + {9'd0, per_q - rem_val};
        end
      end
      ST_AL_ADD: due_d = (fin_sum[DueW+1:DueW] != '0) ? '1 : fin_sum[DueW-1:0];
      ST_AL_DONE: begin
        ram_raddr = '0;
        kind_d = RES_DONE; eid_d = '0; arm_d = 1'b0; ivl_d = '0;
        last_d = 1'b1; after_d = ST_IDLE;
      end
      ST_AL_DLAST: begin
        arm_d = 1'b1;
        ivl_d = head_ivl(rd.due, now_q, miv_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      after_q <= ST_IDLE;
      op_q    <= REQ_ADD;
      cnt_q   <= '0;
      idc_q   <= ID_RESET;
      nf_q    <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      idc_q   <= idc_d;
      nf_q    <= nf_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;  pos_q <= pos_d;  j_q <= j_d;     id_q <= id_d;
    tid_q <= tid_d;  now_q <= now_d;  due_q <= due_d; gap_q <= gap_d;
    per_q <= per_d;  dd_q <= dd_d;    kp_q <= kp_d;
    kind_q <= kind_d; eid_q <= eid_d; arm_q <= arm_d; last_q <= last_d;
    ivl_q <= ivl_d;
    okind_q <= okind_d; oeid_q <= oeid_d; oarm_q <= oarm_d;
    olast_q <= olast_d; oivl_q <= oivl_d; oemp_q <= oemp_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {7'd0, oemp_q, oivl_q, oarm_q, oeid_q};

endmodule
